// File: hdl/cfpl_pkg.sv
`default_nettype none
package cfpl_pkg;
   localparam int FRAC_BITS = 16;

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_DINIT  = 4'd1;
   localparam logic [3:0] ST_DACC   = 4'd2;
   localparam logic [3:0] ST_DSQRT  = 4'd3;
   localparam logic [3:0] ST_DOUT   = 4'd4;
   localparam logic [3:0] ST_OINIT  = 4'd5;
   localparam logic [3:0] ST_OACC   = 4'd6;
   localparam logic [3:0] ST_ODIV   = 4'd7;
   localparam logic [3:0] ST_OOUT   = 4'd8;
   localparam logic [3:0] ST_WAIT   = 4'd9;

   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_ACC  = 2'd1;
   localparam logic [1:0] RD_A    = 2'd2;
   localparam logic [1:0] RD_B    = 2'd3;

   typedef struct packed {
      logic       load_acc;
      logic       mac;
      logic       start_sqrt;
      logic       start_div;
      logic       write_diag;
      logic       write_off;
      logic [1:0] rd_sel;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic acc_pos;
   } status_type;
endpackage
`default_nettype wire

// File: hdl/cfpl_if.sv
`default_nettype none
interface cfpl_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] element_in;
   modport source (output valid, element_in, input ready);
   modport sink (input valid, element_in, output ready);
endinterface

interface cfpl_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] factor_out;
   logic                         last_element;
   logic                         not_positive_definite;
   modport source (output valid, factor_out, last_element, not_positive_definite,
                   input ready);
   modport sink (input valid, factor_out, last_element, not_positive_definite,
                 output ready);
endinterface
`default_nettype wire

// File: hdl/cfpl_datapath.sv
`default_nettype none
module cfpl_datapath
   import cfpl_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 36,
   parameter int AW         = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire                          wr_load,
   input  wire [AW-1:0]                 wr_load_addr,
   input  wire signed [DATA_WIDTH-1:0]  wr_load_data,
   input  wire [AW-1:0]                 rd_addr,
   input  wire [AW-1:0]                 diag_addr,
   input  wire [AW-1:0]                 off_addr,
   output logic signed [DATA_WIDTH-1:0] result,
   output logic                         pivot_zero
);
   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W;
   localparam int SW  = W + FRAC_BITS;        // radicand width
   localparam int RW  = (SW + 1) / 2 + 1;     // root width
   localparam int SC  = (SW + 1) / 2;         // sqrt steps
   localparam int DNW = W + FRAC_BITS + 1;    // dividend magnitude width
   localparam int CW  = $clog2(DNW + 1);
   localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (W - 1)) - 1);
   localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

   logic signed [W-1:0] mem [DEPTH];
   logic signed [W-1:0] rdata_ff, a_ff, b_ff, piv_ff;
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   logic                 prod_v_ff;

   // store: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_load) begin
         mem[wr_load_addr] <= wr_load_data;
      end else if (cmd.write_diag) begin
         mem[diag_addr] <= result;
      end else if (cmd.write_off) begin
         mem[off_addr] <= result;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      case (cmd.rd_sel)
         RD_A:    a_ff <= rdata_ff;
         RD_B:    b_ff <= rdata_ff;
         default: ;
      endcase
   end

   // multiply stage then rounded subtract stage
   logic signed [PW-1:0] rnd, diff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= cmd.mac;
      end
      prod_ff <= PW'(a_ff) * PW'(b_ff);
   end

   always_comb begin
      rnd  = (prod_ff + PW'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      diff = PW'(acc_ff) - rnd;
      acc_in = acc_ff;
      if (cmd.load_acc) begin
         acc_in = rdata_ff;
      end else if (prod_v_ff) begin
         if (diff > MAXV) acc_in = W'(MAXV);
         else if (diff < MINV) acc_in = W'(MINV);
         else acc_in = W'(diff);
      end
   end
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // shared iterative unit: sqrt (2 bits/step) or restoring divide (1 bit/step)
   logic            busy_ff, is_div_ff, neg_ff, special_ff;
   logic [CW-1:0]   cnt_ff;
   logic [SW-1:0]   rad_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [DNW-1:0]  dvd_ff, quo_ff;
   logic [W:0]      dvs_ff, drem_ff;
   logic signed [W-1:0] res_ff;

   logic [RW+1:0] s_rem, s_trial;
   logic [W+1:0]  d_rem;
   logic [DNW+1:0] mag;
   always_comb begin
      s_rem   = {rem_ff[RW-1:0], rad_ff[SW-1 -: 2]};
      s_trial = {root_ff, 2'b01};
      d_rem   = {drem_ff, dvd_ff[DNW-1]};
      mag     = {2'b00, quo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.start_sqrt) begin
         busy_ff    <= 1'b1;
         is_div_ff  <= 1'b0;
         special_ff <= (acc_ff <= 0);
         rad_ff     <= SW'(acc_ff) << FRAC_BITS;
         rem_ff     <= '0;
         root_ff    <= '0;
         cnt_ff     <= CW'(SC);
      end else if (cmd.start_div) begin
         busy_ff    <= 1'b1;
         is_div_ff  <= 1'b1;
         special_ff <= (piv_ff == 0);
         neg_ff     <= acc_ff[W-1] ^ piv_ff[W-1];
         dvd_ff     <= DNW'(acc_ff[W-1] ? -(DNW'(acc_ff)) : DNW'(acc_ff)) << FRAC_BITS;
         dvs_ff     <= piv_ff[W-1] ? (W+1)'(-(W+1)'(piv_ff)) : (W+1)'(piv_ff);
         drem_ff    <= '0;
         quo_ff     <= '0;
         cnt_ff     <= CW'(DNW);
      end else if (busy_ff) begin
         if (cnt_ff == 0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
            if (is_div_ff) begin
               dvd_ff <= dvd_ff << 1;
               if (d_rem >= {1'b0, dvs_ff}) begin
                  drem_ff <= (W+1)'(d_rem - {1'b0, dvs_ff});
                  quo_ff  <= {quo_ff[DNW-2:0], 1'b1};
               end else begin
                  drem_ff <= (W+1)'(d_rem);
                  quo_ff  <= {quo_ff[DNW-2:0], 1'b0};
               end
            end else begin
               rad_ff <= rad_ff << 2;
               if (s_rem >= s_trial) begin
                  rem_ff  <= s_rem - s_trial;
                  root_ff <= {root_ff[RW-2:0], 1'b1};
               end else begin
                  rem_ff  <= s_rem;
                  root_ff <= {root_ff[RW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // final value of the unit
   always_comb begin
      if (!is_div_ff) begin
         res_ff = special_ff ? '0 : W'(root_ff);
      end else if (special_ff) begin
         if (acc_ff > 0) res_ff = W'(MAXV);
         else if (acc_ff < 0) res_ff = W'(MINV);
         else res_ff = '0;
      end else if (neg_ff) begin
         res_ff = (mag > (DNW+2)'(MAXV) + 1) ? W'(MINV) : W'(-mag);
      end else begin
         res_ff = (mag > (DNW+2)'(MAXV)) ? W'(MAXV) : W'(mag);
      end
   end
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_diag) piv_ff <= res_ff;
   end

   assign pivot_zero      = special_ff;
   assign status.busy     = busy_ff || cmd.start_sqrt || cmd.start_div;
   assign status.acc_pos  = (acc_ff > 0);
endmodule
`default_nettype wire

// File: hdl/cfpl_control.sv
`default_nettype none
module cfpl_control
   import cfpl_pkg::*;
#(
   parameter int MAX_ORDER = 8,
   parameter int AW        = 6,
   parameter int OW        = 4
) (
   input  wire           clock,
   input  wire           reset,
   input  wire [3:0]     order_reg,
   input  wire           cfg_write,
   input  wire           req_fire,
   output logic          req_ready,
   output logic          wr_load,
   output logic [AW-1:0] wr_load_addr,
   output cmd_type       cmd,
   input  wire status_type status,
   input  wire           pivot_zero,
   output logic [AW-1:0] rd_addr,
   output logic [AW-1:0] diag_addr,
   output logic [AW-1:0] off_addr,
   output logic          out_valid,
   output logic          out_last,
   output logic          out_err,
   input  wire           out_ready
);
   localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] load_ff;
   logic [OW-1:0] n, j_ff, i_ff, k_ff;
   logic [1:0]    ph_ff;      // read pipeline phase within one MAC
   logic          err_ff, isdiag_ff, waitv_ff;
   logic [AW:0]   total;

   always_comb begin
      if (order_reg == 0) n = OW'(1);
      else if ({1'b0, order_reg} > 5'(MAX_ORDER)) n = OW'(MAX_ORDER);
      else n = OW'(order_reg);
      total = (AW+1)'((n * (n + 1)) >> 1);
   end

   function automatic logic [AW-1:0] pos(input logic [OW-1:0] nn,
                                          input logic [OW-1:0] r,
                                          input logic [OW-1:0] c);
      logic [2*OW+1:0] t;
      t = ({2'b0, c} * ({1'b0, nn, 1'b0} - {2'b0, c} - 1'b1)) >> 1;
      return AW'(t + r);
   endfunction

   assign req_ready    = (state_ff == ST_LOAD);
   assign wr_load      = req_fire;
   assign wr_load_addr = load_ff;
   assign diag_addr    = pos(n, j_ff, j_ff);
   assign off_addr     = pos(n, i_ff, j_ff);
   assign out_valid    = waitv_ff;
   assign out_last     = isdiag_ff && (j_ff == n - 1'b1);
   assign out_err      = err_ff;

   // Each MAC over k: ph 0 read row entry, ph 1 read col entry, ph 2 latch col entry, ph 3 issue.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      rd_addr  = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && ({1'b0, load_ff} + 1'b1 >= total)) state_in = ST_DINIT;
         end
         ST_DINIT: begin
            rd_addr = diag_addr;
            if (ph_ff == 2'd1) begin
               cmd.rd_sel = RD_ACC;
               cmd.load_acc = 1'b1;
               state_in = ST_DACC;
            end
         end
         ST_DACC: begin
            rd_addr = pos(n, j_ff, k_ff);
            if (k_ff == j_ff) begin
               if (ph_ff == 2'd2) begin
                  cmd.start_sqrt = 1'b1;
                  state_in = ST_DSQRT;
               end
            end else if (ph_ff == 2'd1) begin
               cmd.rd_sel = RD_A;
            end else if (ph_ff == 2'd2) begin
               cmd.rd_sel = RD_B;
            end else if (ph_ff == 2'd3) begin
               cmd.mac = 1'b1;
            end
         end
         ST_DSQRT: begin
            if (!status.busy) begin
               cmd.write_diag = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_OINIT: begin
            rd_addr = off_addr;
            if (ph_ff == 2'd1) begin
               cmd.load_acc = 1'b1;
               state_in = ST_OACC;
            end
         end
         ST_OACC: begin
            rd_addr = (ph_ff == 2'd0) ? pos(n, i_ff, k_ff) : pos(n, j_ff, k_ff);
            if (k_ff == j_ff) begin
               if (ph_ff == 2'd2) begin
                  cmd.start_div = 1'b1;
                  state_in = ST_ODIV;
               end
            end else if (ph_ff == 2'd1) begin
               cmd.rd_sel = RD_A;
            end else if (ph_ff == 2'd2) begin
               cmd.rd_sel = RD_B;
            end else if (ph_ff == 2'd3) begin
               cmd.mac = 1'b1;
            end
         end
         ST_ODIV: begin
            if (!status.busy) begin
               cmd.write_off = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_ready) begin
               if (i_ff + 1'b1 < n) state_in = ST_OINIT;
               else if (j_ff + 1'b1 < n) state_in = ST_DINIT;
               else state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         load_ff   <= '0;
         j_ff      <= '0;
         i_ff      <= '0;
         k_ff      <= '0;
         ph_ff     <= '0;
         err_ff    <= 1'b0;
         isdiag_ff <= 1'b0;
         waitv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) load_ff <= '0;
         case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if ({1'b0, load_ff} + 1'b1 >= total) begin
                     load_ff <= '0;
                     j_ff    <= '0;
                     err_ff  <= 1'b0;
                     ph_ff   <= '0;
                  end else begin
                     load_ff <= load_ff + 1'b1;
                  end
               end
            end
            ST_DINIT, ST_OINIT: begin
               ph_ff <= (ph_ff == 2'd1) ? 2'd0 : ph_ff + 1'b1;
               k_ff  <= '0;
            end
            ST_DACC, ST_OACC: begin
               if (k_ff == j_ff) begin
                  ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 1'b1;
               end else if (ph_ff == 2'd3) begin
                  ph_ff <= '0;
                  k_ff  <= k_ff + 1'b1;
               end else begin
                  ph_ff <= ph_ff + 1'b1;
               end
            end
            ST_DSQRT: begin
               if (!status.busy) begin
                  waitv_ff  <= 1'b1;
                  isdiag_ff <= 1'b1;
                  i_ff      <= j_ff;
                  if (pivot_zero) err_ff <= 1'b1;
               end
            end
            ST_ODIV: begin
               if (!status.busy) begin
                  waitv_ff  <= 1'b1;
                  isdiag_ff <= 1'b0;
               end
            end
            ST_WAIT: begin
               if (out_ready) begin
                  waitv_ff <= 1'b0;
                  if (i_ff + 1'b1 < n) begin
                     i_ff <= i_ff + 1'b1;
                  end else if (j_ff + 1'b1 < n) begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   logic unused;
   assign unused = status.acc_pos ^ (DEPTH[0]);
endmodule
`default_nettype wire

// File: hdl/cholesky_factor_packed_lower.sv
`default_nettype none
// Channel | Dir | Handshake    | Payload
// req     | in  | valid/ready  | element_in (signed Q16.16)
// rsp     | out | valid/ready  | factor_out, last_element, not_positive_definite
// csr     | in  | APB write    | reg 0 matrix_order at byte 0
//
// One element loads per cycle while the block is loading. After the last one, a MAC
// and one shared square-root and divide unit work through the factor: each MAC
// term does two store reads, a multiply and a subtract, then each diagonal takes
// a root and each off-diagonal a divide. No requests are taken while factoring.
// Reset is synchronous; a stalled result holds and blocks the factor loop.
module cholesky_factor_packed_lower
   import cfpl_pkg::*;
#(
   parameter int MAX_ORDER  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire          clock,
   input  wire          reset,
   cfpl_req_if.sink     req,
   cfpl_rsp_if.source   rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [1:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(MAX_ORDER + 1);

   logic [3:0] order_ff;
   logic       cfg_write;

   // register write: address 0 holds the order, others are ignored
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0);
   assign csr_prdata = (csr_paddr == 2'd0) ? {28'd0, order_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 4'd8;
      end else if (cfg_write) begin
         order_ff <= csr_pwdata[3:0];
      end
   end

   cmd_type       cmd;
   status_type    status;
   logic          wr_load, pivot_zero, req_ready;
   logic [AW-1:0] wr_load_addr, rd_addr, diag_addr, off_addr;
   logic signed [DATA_WIDTH-1:0] result;

   assign req.ready = req_ready;

   cfpl_control #(.MAX_ORDER(MAX_ORDER), .AW(AW), .OW(OW)) u_ctrl (
      .clock, .reset,
      .order_reg    (order_ff),
      .cfg_write    (cfg_write),
      .req_fire     (req.valid && req_ready),
      .req_ready    (req_ready),
      .wr_load, .wr_load_addr, .cmd, .status, .pivot_zero,
      .rd_addr, .diag_addr, .off_addr,
      .out_valid    (rsp.valid),
      .out_last     (rsp.last_element),
      .out_err      (rsp.not_positive_definite),
      .out_ready    (rsp.ready)
   );

   // result register: latched when the unit finishes, held through stalls
   logic signed [DATA_WIDTH-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (cmd.write_diag || cmd.write_off) out_ff <= result;
   end
   assign rsp.factor_out = out_ff;

   cfpl_datapath #(.DATA_WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_dp (
      .clock, .reset, .cmd, .status,
      .wr_load, .wr_load_addr,
      .wr_load_data (req.element_in),
      .rd_addr, .diag_addr, .off_addr,
      .result, .pivot_zero
   );
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cfpl_pkg::*;

   localparam int ORDER_MAX = 8;
   localparam int DW        = 32;
   localparam int DEPTH     = ORDER_MAX * (ORDER_MAX + 1) / 2;
   localparam int WATCHDOG  = 5000;   // idle cycles without any request or result
   localparam int SETTLE    = 80;     // cycles after the last result before a csr write
   localparam logic [1:0] ADDR_MATRIX_ORDER = 2'd0;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   typedef struct {
      logic [31:0] factor;
      logic        last;
      logic        npd;
   } factor_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfpl_req_if #(.DATA_WIDTH(DW)) req_ch ();
   cfpl_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [1:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cholesky_factor_packed_lower #(.MAX_ORDER(ORDER_MAX), .DATA_WIDTH(DW)) dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow of the block: order register, triangle store, load count
   // ---------------------------------------------------------------
   logic [3:0]     order_reg;
   longint         tri_store [DEPTH];
   int             loaded;
   logic           pivot_bad;
   factor_rsp_type factor_q[$];

   logic [31:0] pending_elems[$];
   int          sent_cnt, taken_cnt;
   int          errors;
   bit          req_fast, rsp_fast;
   int          rsp_hold;          // long receiver stall, counted by the receiver

   function automatic int eff_order();
      if (order_reg == 4'd0) return 1;
      if (order_reg > ORDER_MAX) return ORDER_MAX;
      return int'(order_reg);
   endfunction

   function automatic int tri_pos(int n, int r, int c);
      return (c * (2 * n - c - 1)) / 2 + r;
   endfunction

   function automatic longint clamp_q(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   // round to nearest, ties up: floor((a*b + half) / 2^16)
   function automatic longint mul_q(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return p >>> FRAC_BITS;
   endfunction

   function automatic longint div_q(longint a, longint d);
      if (d == 0) begin
         if (a > 0) return QMAX;
         if (a < 0) return QMIN;
         return 0;
      end
      return clamp_q((a * 64'sd65536) / d);
   endfunction

   function automatic longint sqrt_q(longint v);
      longint unsigned x, res, b;
      x = longint'(v) << FRAC_BITS;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   // Left-looking factor over the shadow store; queues every factor element.
   task automatic factor_triangle(int n);
      longint acc, e;
      int dj, p;
      factor_rsp_type r;
      pivot_bad = 1'b0;
      for (int j = 0; j < n; j++) begin
         dj = tri_pos(n, j, j);
         acc = tri_store[dj];
         for (int k = 0; k < j; k++) begin
            e = tri_store[tri_pos(n, j, k)];
            acc = clamp_q(acc - mul_q(e, e));
         end
         if (acc <= 0) begin
            pivot_bad = 1'b1;
            tri_store[dj] = 0;
         end else begin
            tri_store[dj] = sqrt_q(acc);
         end
         r.factor = tri_store[dj][31:0];
         r.last   = (j == n - 1);
         r.npd    = pivot_bad;
         factor_q.push_back(r);
         for (int i = j + 1; i < n; i++) begin
            p = tri_pos(n, i, j);
            acc = tri_store[p];
            for (int k = 0; k < j; k++)
               acc = clamp_q(acc - mul_q(tri_store[tri_pos(n, i, k)],
                                         tri_store[tri_pos(n, j, k)]));
            tri_store[p] = div_q(acc, tri_store[dj]);
            r.factor = tri_store[p][31:0];
            r.last   = 1'b0;
            r.npd    = pivot_bad;
            factor_q.push_back(r);
         end
      end
   endtask

   task automatic load_element(logic signed [31:0] v);
      int n, total;
      n = eff_order();
      total = n * (n + 1) / 2;
      if (loaded >= total) loaded = 0;
      tri_store[loaded] = longint'(v);
      loaded++;
      if (loaded == total) begin
         loaded = 0;
         factor_triangle(n);
      end
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Request driver: changes at the falling edge
   // ---------------------------------------------------------------
   bit req_fire, rsp_fire;
   int req_gap, rsp_gap;

   always @(negedge clock) begin
      logic nv;
      nv = req_ch.valid;
      if (reset) begin
         nv = 1'b0;
         req_gap <= 0;
      end else begin
         if (req_fire) nv = 1'b0;
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
            end else if (pending_elems.size() > 0) begin
               req_ch.element_in <= pending_elems.pop_front();
               nv = 1'b1;
               req_gap <= req_fast ? 0 : $urandom_range(0, 9);
            end
         end
      end
      req_ch.valid <= nv;
   end

   // Result receiver: random per-result stall, plus an optional long hold-off
   always @(negedge clock) begin
      logic nr;
      nr = 1'b0;
      if (reset) begin
         rsp_gap <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_fire) begin
         rsp_gap <= rsp_fast ? 0 : $urandom_range(0, 9);
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
      end else begin
         nr = 1'b1;
      end
      rsp_ch.ready <= nr;
   end

   // ---------------------------------------------------------------
   // Monitor: samples at the rising edge, predicts and checks
   // ---------------------------------------------------------------
   int quiet;
   always @(posedge clock) begin
      factor_rsp_type w;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      if (req_fire) begin
         taken_cnt++;
         load_element(req_ch.element_in);
      end
      if (rsp_fire) begin
         if (factor_q.size() == 0) begin
            report("unexpected result", rsp_ch.factor_out, '0);
         end else begin
            w = factor_q.pop_front();
            if (rsp_ch.factor_out !== w.factor) report("factor_out", rsp_ch.factor_out, w.factor);
            if (rsp_ch.last_element !== w.last)
               report("last_element", rsp_ch.last_element, w.last);
            if (rsp_ch.not_positive_definite !== w.npd)
               report("not_positive_definite", rsp_ch.not_positive_definite, w.npd);
         end
      end
      // watchdog
      if (req_fire || rsp_fire || reset) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
         $display("watchdog expired");
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   task automatic csr_write_order(logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_MATRIX_ORDER; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      order_reg = v[3:0];
      loaded = 0;
   endtask

   // all requests taken and every factor element back, then let the block settle
   task automatic drain();
      while (pending_elems.size() > 0 || taken_cnt != sent_cnt || factor_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send(logic [31:0] v);
      pending_elems.push_back(v);
      sent_cnt++;
   endtask

   // Mostly diagonally dominant matrices (they factor cleanly); some pure noise.
   task automatic send_matrix(int n, bit noise);
      int sh;
      logic [31:0] off;
      sh = $urandom_range(4, 18);
      for (int c = 0; c < n; c++)
         for (int r = c; r < n; r++) begin
            if (noise) begin
               send($urandom);
            end else if (r == c) begin
               send((n << sh) + $urandom_range(1, 1 << sh));
            end else begin
               off = $urandom_range(0, 1 << sh);
               send($urandom_range(0, 1) ? off : -off);
            end
         end
   endtask

   int n_items, n_mats, ord, kind;

   initial begin
      order_reg  = 4'd8;
      loaded     = 0;
      pivot_bad  = 1'b0;
      errors     = 0;
      sent_cnt   = 0;
      taken_cnt  = 0;
      req_fast   = 1'b0;
      rsp_fast   = 1'b0;
      rsp_hold   = 0;
      quiet      = 0;
      req_ch.valid = 1'b0;
      req_ch.element_in = '0;
      rsp_ch.ready = 1'b0;
      foreach (tri_store[i]) tri_store[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // order 1: extremes, zero pivot, negative pivot
      csr_write_order(32'd1);
      send(32'h7fffffff); send(32'h80000000); send(32'h0); send(32'h00010000);
      drain();
      // order 0 behaves as 1
      csr_write_order(32'd0);
      send(32'h00040000);
      drain();
      // zero pivot feeding the division: positive, negative and zero numerators
      csr_write_order(32'd4);
      send(32'h0); send(32'h00050000); send(32'hfffb0000); send(32'h0);
      send(32'h00100000); send(32'h0); send(32'h0);
      send(32'h00100000); send(32'h0);
      send(32'h00100000);
      drain();
      // saturation: huge off-diagonal over a tiny pivot
      csr_write_order(32'd2);
      send(32'h00000001); send(32'h7fffffff); send(32'h80000000);
      drain();
      // order written mid-load drops the partial matrix
      csr_write_order(32'd3);
      send(32'h00010000); send(32'h00020000);
      drain();
      csr_write_order(32'd15);   // above the maximum, acts as 8
      send_matrix(ORDER_MAX, 1'b0);
      drain();

      // random part; long receiver hold-off while the sender keeps going
      n_items = sent_cnt;
      csr_write_order(32'd2);
      rsp_hold = 400;
      for (int m = 0; m < 6; m++) send_matrix(2, 1'b0);
      n_items += 18;
      drain();
      while (n_items < 320) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) ord = 0;
         else if (kind == 1) ord = $urandom_range(9, 15);
         else if (kind < 5) ord = $urandom_range(5, 8);
         else ord = $urandom_range(1, 4);
         csr_write_order(ord);
         req_fast = ($urandom_range(0, 3) == 0);
         rsp_fast = ($urandom_range(0, 3) == 0);
         ord = eff_order();
         n_mats = $urandom_range(1, 4);
         for (int m = 0; m < n_mats; m++) begin
            send_matrix(ord, $urandom_range(0, 3) == 0);
            n_items += ord * (ord + 1) / 2;
         end
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
